### rtl/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

  // Channel and result widths
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned TDATA_W = 3 * CHAN_W;

  // Divider geometry: one quotient bit per cell
  localparam int unsigned QUO_W = CHAN_W;
  localparam int unsigned NCELLS = QUO_W;
  localparam int unsigned REM_W = 2 * CHAN_W;
  localparam int unsigned DSH_W = CHAN_W + QUO_W - 1;
  localparam int unsigned PROD_W = 14;

  // Hue sectors
  localparam int unsigned SECTOR_SIZE = 85;
  localparam int unsigned SECTOR_SLOPE = SECTOR_SIZE / 2;
  localparam logic [CHAN_W-1:0] OFF_RED = CHAN_W'(0);
  localparam logic [CHAN_W-1:0] OFF_GREEN = CHAN_W'(SECTOR_SIZE);
  localparam logic [CHAN_W-1:0] OFF_BLUE = CHAN_W'(2 * SECTOR_SIZE);

  // Payload handed from cell to cell
  typedef struct packed {
    logic [REM_W-1:0]  s_rem;   // saturation partial remainder
    logic [DSH_W-1:0]  s_dsh;   // aligned saturation divisor (max)
    logic [QUO_W-1:0]  s_quo;
    logic [REM_W-1:0]  h_rem;   // hue partial remainder (magnitude)
    logic [DSH_W-1:0]  h_dsh;   // aligned hue divisor (spread)
    logic [QUO_W-1:0]  h_quo;
    logic              h_neg;   // hue numerator was negative
    logic [CHAN_W-1:0] h_off;   // sector offset
    logic [CHAN_W-1:0] val;     // largest channel
    logic              black;   // largest channel is zero
  } lane_t;

  // Stage control between neighbours
  typedef struct packed {
    logic valid;
    logic en;
  } stage_ctl_t;

endpackage

`default_nettype wire

### rtl/rgb_to_hsv_8bit_core.sv
`default_nettype none

// Ten register stages from input transaction to out_tvalid
// (front stage loaded on the accepting edge, eight divider cells at one
// quotient bit each, output register).
// Throughput: one pixel per cycle; the whole pipe advances together and
// holds while a finished result waits on out_tready.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
module rgb_to_hsv_8bit_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  input  wire logic [rgbhsv_pkg::TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [7:0] hue, [15:8] saturation, [23:16] brightness_value
  output logic [rgbhsv_pkg::TDATA_W-1:0]          out_tdata
);

  localparam int unsigned CW = rgbhsv_pkg::CHAN_W;

  logic                   en;
  rgbhsv_pkg::stage_ctl_t ctl [0:rgbhsv_pkg::NCELLS];
  rgbhsv_pkg::lane_t      lane [0:rgbhsv_pkg::NCELLS];
  logic                   valid [0:rgbhsv_pkg::NCELLS];
  logic [CW-1:0]          hq;
  logic [CW-1:0]          hue_nxt;
  logic [CW-1:0]          sat_nxt;
  logic                   out_valid_r;
  logic [rgbhsv_pkg::TDATA_W-1:0] out_data_r;

  // Pipe advances unless a result is stuck at the output
  assign en        = out_tready || !out_valid_r;
  assign in_tready = en;

  assign ctl[0].valid = in_tvalid;
  assign ctl[0].en    = en;

  rgbhsv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl[0]),
    .red     (in_tdata[CW-1:0]),
    .green   (in_tdata[2*CW-1:CW]),
    .blue    (in_tdata[3*CW-1:2*CW]),
    .lane_o  (lane[0]),
    .valid_o (valid[0])
  );

  // Divider chain
  for (genvar i = 0; i < rgbhsv_pkg::NCELLS; i++) begin : g_cell
    assign ctl[i+1].valid = valid[i];
    assign ctl[i+1].en    = en;
    rgbhsv_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[i+1]),
      .lane_i  (lane[i]),
      .lane_o  (lane[i+1]),
      .valid_o (valid[i+1])
    );
  end

  // Sign, sector offset and the black / grey cases
  always_comb begin
    hq = lane[rgbhsv_pkg::NCELLS].h_neg ? (CW'(0) - lane[rgbhsv_pkg::NCELLS].h_quo)
                                        : lane[rgbhsv_pkg::NCELLS].h_quo;
    sat_nxt = lane[rgbhsv_pkg::NCELLS].black ? '0 : lane[rgbhsv_pkg::NCELLS].s_quo;
    if (sat_nxt == '0) begin
      hue_nxt = '0;
    end else begin
      hue_nxt = hq + lane[rgbhsv_pkg::NCELLS].h_off;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid[rgbhsv_pkg::NCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {lane[rgbhsv_pkg::NCELLS].val, sat_nxt, hue_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3*CW-1:2*CW] == '0 |-> out_tdata[2*CW-1:0] == '0)
    else $error("black pixel with nonzero hue or saturation");

  // Zero saturation forces zero hue
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2*CW-1:CW] == '0 |-> out_tdata[CW-1:0] == '0)
    else $error("grey pixel with nonzero hue");

  // Saturation division finished: remainder below the divisor
  a_srem: assert property (@(posedge clk) disable iff (!rst_n)
    valid[rgbhsv_pkg::NCELLS] && !lane[rgbhsv_pkg::NCELLS].black |->
    lane[rgbhsv_pkg::NCELLS].s_rem < rgbhsv_pkg::REM_W'(lane[rgbhsv_pkg::NCELLS].val))
    else $error("saturation remainder not reduced");

  // A held result leaves the whole pipe frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(valid[rgbhsv_pkg::NCELLS]))
    else $error("pipe moved while output stalled");

endmodule

`default_nettype wire

### rtl/rgbhsv_front.sv
`default_nettype none

module rgbhsv_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rgbhsv_pkg::stage_ctl_t            ctl_i,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]     red,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]     green,
  input  wire logic [rgbhsv_pkg::CHAN_W-1:0]     blue,
  output rgbhsv_pkg::lane_t                      lane_o,
  output logic                                   valid_o
);

  logic [rgbhsv_pkg::CHAN_W-1:0] mx;
  logic [rgbhsv_pkg::CHAN_W-1:0] mn;
  logic [rgbhsv_pkg::CHAN_W-1:0] spread;
  logic [rgbhsv_pkg::CHAN_W-1:0] hx;
  logic [rgbhsv_pkg::CHAN_W-1:0] hy;
  logic [rgbhsv_pkg::CHAN_W-1:0] off;
  logic                          d_neg;
  logic [rgbhsv_pkg::CHAN_W-1:0] dmag;
  logic [rgbhsv_pkg::PROD_W-1:0] prod;
  logic [rgbhsv_pkg::PROD_W-1:0] half;
  logic [rgbhsv_pkg::PROD_W-1:0] hmag;
  logic                          hneg;
  logic [rgbhsv_pkg::REM_W-1:0]  snum;
  rgbhsv_pkg::lane_t             lane_nxt;
  rgbhsv_pkg::lane_t             lane_r;
  logic                          valid_r;

  // Max, min and dominant channel (red, green, blue priority on ties)
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    spread = mx - mn;
    if (mx == red) begin
      hx  = green;
      hy  = blue;
      off = rgbhsv_pkg::OFF_RED;
    end else if (mx == green) begin
      hx  = blue;
      hy  = red;
      off = rgbhsv_pkg::OFF_GREEN;
    end else begin
      hx  = red;
      hy  = green;
      off = rgbhsv_pkg::OFF_BLUE;
    end
  end

  // Hue numerator as sign and magnitude: diff*slope + spread/2
  always_comb begin
    d_neg = hy > hx;
    dmag  = d_neg ? (hy - hx) : (hx - hy);
    prod  = rgbhsv_pkg::PROD_W'(dmag) *
            rgbhsv_pkg::PROD_W'(rgbhsv_pkg::SECTOR_SLOPE);
    half  = rgbhsv_pkg::PROD_W'(spread[rgbhsv_pkg::CHAN_W-1:1]);
    if (!d_neg) begin
      hmag = prod + half;
      hneg = 1'b0;
    end else if (half >= prod) begin
      hmag = half - prod;
      hneg = 1'b0;
    end else begin
      hmag = prod - half;
      hneg = 1'b1;
    end
  end

  // Saturation numerator: 255*spread + max/2
  assign snum = {spread, rgbhsv_pkg::CHAN_W'(0)} - rgbhsv_pkg::REM_W'(spread)
              + rgbhsv_pkg::REM_W'(mx[rgbhsv_pkg::CHAN_W-1:1]);

  always_comb begin
    lane_nxt.s_rem = snum;
    lane_nxt.s_dsh = {mx, (rgbhsv_pkg::QUO_W-1)'(0)};
    lane_nxt.s_quo = '0;
    lane_nxt.h_rem = rgbhsv_pkg::REM_W'(hmag);
    lane_nxt.h_dsh = {spread, (rgbhsv_pkg::QUO_W-1)'(0)};
    lane_nxt.h_quo = '0;
    lane_nxt.h_neg = hneg;
    lane_nxt.h_off = off;
    lane_nxt.val   = mx;
    lane_nxt.black = (mx == '0);
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_i.en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o  = lane_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

### rtl/rgbhsv_cell.sv
`default_nettype none

module rgbhsv_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rgbhsv_pkg::stage_ctl_t ctl_i,
  input  wire rgbhsv_pkg::lane_t      lane_i,
  output rgbhsv_pkg::lane_t           lane_o,
  output logic                        valid_o
);

  logic              s_ge;
  logic              h_ge;
  rgbhsv_pkg::lane_t lane_nxt;
  rgbhsv_pkg::lane_t lane_r;
  logic              valid_r;

  // One restoring step for each divider
  assign s_ge = lane_i.s_rem >= rgbhsv_pkg::REM_W'(lane_i.s_dsh);
  assign h_ge = lane_i.h_rem >= rgbhsv_pkg::REM_W'(lane_i.h_dsh);

  always_comb begin
    lane_nxt       = lane_i;
    lane_nxt.s_rem = s_ge ? (lane_i.s_rem - rgbhsv_pkg::REM_W'(lane_i.s_dsh))
                          : lane_i.s_rem;
    lane_nxt.s_quo = {lane_i.s_quo[rgbhsv_pkg::QUO_W-2:0], s_ge};
    lane_nxt.s_dsh = lane_i.s_dsh >> 1;
    lane_nxt.h_rem = h_ge ? (lane_i.h_rem - rgbhsv_pkg::REM_W'(lane_i.h_dsh))
                          : lane_i.h_rem;
    lane_nxt.h_quo = {lane_i.h_quo[rgbhsv_pkg::QUO_W-2:0], h_ge};
    lane_nxt.h_dsh = lane_i.h_dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_i.en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o  = lane_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

### test/tb_rgb_to_hsv_8bit_core.sv
`default_nettype none

module tb_rgb_to_hsv_8bit_core;

  localparam int unsigned RANDOM_PIXELS = 1100;
  localparam int unsigned PIPE_LATENCY = 10;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned HOLD_OFF_AFTER = 400;

  typedef logic [rgbhsv_pkg::CHAN_W-1:0] chan_t;

  // One converted pixel, laid out as on out_tdata
  typedef struct packed {
    chan_t val;
    chan_t sat;
    chan_t hue;
  } hsv_t;

  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    bit    typed;
    chan_t hue;
    chan_t sat;
    chan_t val;
  } pixel_row_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_THREE_OF_FOUR,
    READY_RARE
  } stall_mode_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [rgbhsv_pkg::TDATA_W-1:0] in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [rgbhsv_pkg::TDATA_W-1:0] out_tdata;

  hsv_t hsv_pending[$];
  int   mismatches = 0;
  int   pixels_accepted = 0;
  int   burst_left = 0;

  // Directed pixels: extremes, primaries, ties, greys and hue wrap-around
  pixel_row_t directed_rows [20] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd0,   8'd0,   1'b1, 8'd0,   8'd255, 8'd255},
    '{8'd0,   8'd255, 8'd0,   1'b1, 8'd85,  8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd255, 1'b1, 8'd170, 8'd255, 8'd255},
    '{8'd128, 8'd128, 8'd128, 1'b1, 8'd0,   8'd0,   8'd128},
    '{8'd1,   8'd0,   8'd0,   1'b1, 8'd0,   8'd255, 8'd1},
    '{8'd255, 8'd0,   8'd10,  1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd1,   8'd1,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd200, 8'd50,  8'd60,  1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd50,  8'd60,  8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd60,  8'd200, 8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd254, 8'd1,   8'd127, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd85,  8'd170, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd0,   8'd10,  8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
    '{8'd170, 8'd85,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0}
  };

  rgb_to_hsv_8bit_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock, period 12
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Integer HSV of one pixel; int division truncates toward zero
  function automatic hsv_t convert_pixel(input chan_t red, input chan_t green,
                                         input chan_t blue);
    hsv_t res;
    int   r;
    int   g;
    int   b;
    int   hi;
    int   lo;
    int   spread;
    int   sat;
    int   diff;
    int   offset;
    int   num;
    r = int'(red);
    g = int'(green);
    b = int'(blue);
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    res = '0;
    res.val = chan_t'(hi);
    if (hi == 0) begin
      return res;
    end
    spread = hi - lo;
    sat = (255 * spread + hi / 2) / hi;
    res.sat = chan_t'(sat);
    if (sat == 0 || spread == 0) begin
      return res;
    end
    // dominant channel, red wins ties, then green
    if (hi == r) begin
      diff = g - b;
      offset = int'(rgbhsv_pkg::OFF_RED);
    end else if (hi == g) begin
      diff = b - r;
      offset = int'(rgbhsv_pkg::OFF_GREEN);
    end else begin
      diff = r - g;
      offset = int'(rgbhsv_pkg::OFF_BLUE);
    end
    num = (diff * int'(rgbhsv_pkg::SECTOR_SLOPE) + spread / 2) / spread + offset;
    res.hue = chan_t'(num);
    return res;
  endfunction

  // Offer one pixel in the current burst; expectation is recorded on acceptance
  task automatic offer_pixel(input chan_t red, input chan_t green, input chan_t blue,
                             input hsv_t expected);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= rgbhsv_pkg::TDATA_W'($urandom());
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {blue, green, red};
    do @(posedge clk); while (!in_tready);
    hsv_pending.push_back(expected);
    pixels_accepted++;
    @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    chan_t red;
    chan_t green;
    chan_t blue;
    int    shape;
    int    settle;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        offer_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                    '{val: directed_rows[i].val, sat: directed_rows[i].sat,
                      hue: directed_rows[i].hue});
      end else begin
        offer_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                    convert_pixel(directed_rows[i].red, directed_rows[i].green,
                                  directed_rows[i].blue));
      end
    end

    // random pixels, with some weight on ties, greys and tiny spreads
    repeat (RANDOM_PIXELS) begin
      red   = chan_t'($urandom_range(0, 255));
      green = chan_t'($urandom_range(0, 255));
      blue  = chan_t'($urandom_range(0, 255));
      shape = $urandom_range(0, 19);
      case (shape)
        0: begin
          green = red;
        end
        1: begin
          blue = green;
        end
        2: begin
          blue = red;
        end
        3: begin
          green = red;
          blue  = red;
        end
        4: begin
          green = red ^ chan_t'($urandom_range(0, 1));
          blue  = red ^ chan_t'($urandom_range(0, 3));
        end
        5: begin
          red   = chan_t'($urandom_range(0, 3));
          green = chan_t'($urandom_range(0, 3));
          blue  = chan_t'($urandom_range(0, 3));
        end
        default: begin
        end
      endcase
      offer_pixel(red, green, blue, convert_pixel(red, green, blue));
    end
    in_tvalid <= 1'b0;

    // drain, then let the pipe settle
    while (hsv_pending.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 2 * PIPE_LATENCY) begin
      @(posedge clk);
      settle++;
    end
    if (mismatches == 0 && hsv_pending.size() == 0) begin
      $display("tb_rgb_to_hsv_8bit_core passed");
    end else begin
      $display("tb_rgb_to_hsv_8bit_core failed");
    end
    $finish;
  end

  // Receiver: changing stall patterns, plus one long hold-off to fill the pipe
  initial begin : receiver
    stall_mode_t mode;
    int          span;
    int          tick;
    bit          held_off;
    out_tready = 1'b0;
    held_off   = 1'b0;
    tick       = 0;
    @(posedge rst_n);
    forever begin
      if (!held_off && pixels_accepted >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          READY_ALWAYS:        out_tready <= 1'b1;
          READY_COIN:          out_tready <= 1'($urandom_range(0, 1));
          READY_THREE_OF_FOUR: out_tready <= (tick % 4) != 0;
          READY_RARE:          out_tready <= ($urandom_range(0, 7) == 0);
          default:             out_tready <= 1'b1;
        endcase
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    hsv_t got;
    hsv_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = hsv_t'(out_tdata);
      if (hsv_pending.size() == 0) begin
        $error("unexpected transaction: out_tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = hsv_pending.pop_front();
        if (got.hue !== want.hue) begin
          $error("hue: expected %0d, got %0d", want.hue, got.hue);
          mismatches++;
        end
        if (got.sat !== want.sat) begin
          $error("saturation: expected %0d, got %0d", want.sat, got.sat);
          mismatches++;
        end
        if (got.val !== want.val) begin
          $error("brightness_value: expected %0d, got %0d", want.val, got.val);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with no transaction on either side
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb_rgb_to_hsv_8bit_core failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

### filelist.f
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_front.sv
rtl/rgbhsv_cell.sv
rtl/rgb_to_hsv_8bit_core.sv
test/tb_rgb_to_hsv_8bit_core.sv
